@@ hdl/sba_pkg.sv @@
// shared constants, types and helpers of the scaled blit address generator
// no dependencies; used by sba_mac, sba_div and scaled_blit_address_generator
package sba_pkg;

  // coordinate and pitch widths
  localparam int CB = 13;
  localparam int PB = 16;

  // offsets and pixel words
  localparam int OFF_W  = 32;
  localparam int WORD_W = 32;
  localparam int BC_W   = 3;

  // configuration register widths
  localparam int RECT_W  = 4 * CB;
  localparam int SIZE_W  = 2 * CB;
  localparam int PITCH_W = 2 * PB;
  localparam int MODE_W  = 3;
  localparam int CFG_W   = (RECT_W > PITCH_W) ? RECT_W : PITCH_W;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_RECT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_RECT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCHES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE = 3'd5;

  // mode register bit positions
  localparam int MODE_SFMT = 0;
  localparam int MODE_DFMT = 1;
  localparam int MODE_PAD  = 2;

  // request kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd2;

  // pixel sizes in bytes and the opaque alpha
  localparam logic [BC_W-1:0] PIX_A8   = 3'd1;
  localparam logic [BC_W-1:0] PIX_BGRA = 3'd4;
  localparam logic [7:0]      ALPHA_OPAQUE = 8'd255;

  // shared multiply-add operand widths
  localparam int MA_W = CB + 1;
  localparam int MB_W = (CB > PB) ? CB : PB;

  // divider: dividend of two coordinates, one quotient bit per step
  localparam int DIVD_W = 2 * CB;
  localparam int DIV_CNT_W = $clog2(CB + 1);

  // stream widths
  localparam int IN_TDATA_W = WORD_W;
  localparam int RES_W = 1 + OFF_W + OFF_W + 1 + WORD_W + BC_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - RES_W;

  // one result item
  typedef struct packed {
    logic              status;
    logic [OFF_W-1:0]  rd;
    logic [OFF_W-1:0]  wr;
    logic              we;
    logic              last;
    logic [WORD_W-1:0] word;
    logic [BC_W-1:0]   bc;
  } res_t;

  // pixel size for a format bit
  function automatic logic [BC_W-1:0] pix_bytes(input logic bgra);
    return bgra ? PIX_BGRA : PIX_A8;
  endfunction

endpackage

@@ hdl/scaled_blit_address_generator.sv @@
// scaled blit address generator: sequencer, walk state and configuration
// depends on sba_pkg, sba_mac and sba_div
//
// Usage: configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while no request is in flight. Requests enter on the s_axis
// group (tuser = kind, tdata = source word); every request gives exactly one
// result on the m_axis group, with tlast marking the last pixel of a walk.
// A start request checks both rectangles and restarts the walk; advance
// requests step through the destination rectangle one pixel each; convert
// requests translate one pixel word between A8 and BGRA8.
// After the request handshake a start, a convert and an advance that copies
// nothing or is skipped early go straight to the response state; an unscaled
// copy first passes the read and write offset states, and a scaled copy before
// them multiplies and divides for each axis, ending early past the source edge.
// s_axis_tready is high only between requests, so no new request is taken
// before the last one reaches the result register; in the scaled case the
// shared divider yields one quotient bit per cycle for each axis in turn,
// and all offsets pass through a single shared multiply-add unit.
// Reset clears the configuration, the walk position and the running flag.
// A stalled receiver holds the result register; the block finishes the next
// request and then waits in its response state until the register frees.
module scaled_blit_address_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [sba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sba_pkg::CFG_W-1:0]        cfg_data_i,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // src_word
  input  logic [sba_pkg::KIND_W-1:0]       s_axis_tuser,  // kind
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, read_offset, write_offset, write_enable, out_word, byte_count, zeros
  output logic [sba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast   // last_pixel
);

  localparam int CB = sba_pkg::CB;
  localparam int PB = sba_pkg::PB;
  localparam logic [CB+1:0] ONE_X = (CB+2)'(1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MULX  = 10'b0000000010,
    ST_DIVX  = 10'b0000000100,
    ST_WAITX = 10'b0000001000,
    ST_MULY  = 10'b0000010000,
    ST_DIVY  = 10'b0000100000,
    ST_WAITY = 10'b0001000000,
    ST_RDOFF = 10'b0010000000,
    ST_WROFF = 10'b0100000000,
    ST_RESP  = 10'b1000000000
  } state_e;

  // configuration registers
  logic [sba_pkg::RECT_W-1:0]  src_area_q, dst_rect_q;
  logic [sba_pkg::SIZE_W-1:0]  src_size_q, dst_size_q;
  logic [sba_pkg::PITCH_W-1:0] pitches_q;
  logic [sba_pkg::MODE_W-1:0]  mode_q;

  // sequencer and walk state
  state_e          state_q, state_d;
  logic [CB-1:0]   column_q, column_d, row_q, row_d;
  logic            running_q, running_d;
  logic [CB-1:0]   x_q, x_d, y_q, y_d, sx_q, sx_d, sy_q, sy_d;
  sba_pkg::res_t   res_q, res_d, out_q, out_d;
  logic            m_valid_q, m_valid_d;

  // register fields
  logic [CB-1:0] sl, st, sr, sb, dl, dt, dr, db;
  logic [CB-1:0] s_w, s_h, d_w, d_h;
  logic [PB-1:0] sp, dp;
  logic          sfmt, dfmt, pad;

  // derived geometry
  logic [CB-1:0]   dw_c, dh_c, sw_c, sh_c;
  logic [CB:0]     dw_x, dh_x, sw_x, sh_x;
  logic            dw_pos, dh_pos, sw_pos, sh_pos, scaling, bounds_ok;
  logic            x_end, y_end, x_in, y_in;
  logic [CB+1:0]   sx_lin, sy_lin, sx_pad, sy_pad;
  logic            sx_over, sy_over;
  logic [CB:0]     sx_sc, sy_sc;
  logic [CB:0]     dy_lin, dx_lin;
  logic [sba_pkg::WORD_W-1:0] conv_word;

  // shared units
  logic                       mac_en;
  logic [sba_pkg::MA_W-1:0]   mac_a;
  logic [sba_pkg::MB_W-1:0]   mac_b;
  logic [sba_pkg::OFF_W-1:0]  mac_c, mac_res;
  logic                       div_start, div_done;
  logic [sba_pkg::DIVD_W-1:0] div_dividend;
  logic [CB-1:0]              div_divisor, div_quot;

  // clamp to [lo, hi-1], lower bound wins
  function automatic logic [CB+1:0] clamp_pad(input logic [CB+1:0] v,
                                               input logic [CB-1:0] lo,
                                               input logic [CB-1:0] hi);
    logic signed [CB+1:0] hm1;
    logic signed [CB+1:0] r;
    hm1 = $signed({2'b00, hi} - ONE_X);
    r   = $signed(v);
    if (r > hm1) r = hm1;
    if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_area_q <= '0;
      dst_rect_q <= '0;
      src_size_q <= '0;
      dst_size_q <= '0;
      pitches_q  <= '0;
      mode_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sba_pkg::REG_SRC_RECT:  src_area_q <= cfg_data_i[sba_pkg::RECT_W-1:0];
        sba_pkg::REG_DST_RECT:  dst_rect_q <= cfg_data_i[sba_pkg::RECT_W-1:0];
        sba_pkg::REG_SRC_SIZE:  src_size_q <= cfg_data_i[sba_pkg::SIZE_W-1:0];
        sba_pkg::REG_DST_SIZE:  dst_size_q <= cfg_data_i[sba_pkg::SIZE_W-1:0];
        sba_pkg::REG_PITCHES:   pitches_q  <= cfg_data_i[sba_pkg::PITCH_W-1:0];
        sba_pkg::REG_BLIT_MODE: mode_q     <= cfg_data_i[sba_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // field extraction
  assign sl   = src_area_q[0*CB +: CB];
  assign st   = src_area_q[1*CB +: CB];
  assign sr   = src_area_q[2*CB +: CB];
  assign sb   = src_area_q[3*CB +: CB];
  assign dl   = dst_rect_q[0*CB +: CB];
  assign dt   = dst_rect_q[1*CB +: CB];
  assign dr   = dst_rect_q[2*CB +: CB];
  assign db   = dst_rect_q[3*CB +: CB];
  assign s_w  = src_size_q[0 +: CB];
  assign s_h  = src_size_q[CB +: CB];
  assign d_w  = dst_size_q[0 +: CB];
  assign d_h  = dst_size_q[CB +: CB];
  assign sp   = pitches_q[0 +: PB];
  assign dp   = pitches_q[PB +: PB];
  assign sfmt = mode_q[sba_pkg::MODE_SFMT];
  assign dfmt = mode_q[sba_pkg::MODE_DFMT];
  assign pad  = mode_q[sba_pkg::MODE_PAD];

  // rectangle extents and scaling decision
  assign dw_c   = dr - dl;
  assign dh_c   = db - dt;
  assign sw_c   = sr - sl;
  assign sh_c   = sb - st;
  assign dw_x   = {1'b0, dr} - {1'b0, dl};
  assign dh_x   = {1'b0, db} - {1'b0, dt};
  assign sw_x   = {1'b0, sr} - {1'b0, sl};
  assign sh_x   = {1'b0, sb} - {1'b0, st};
  assign dw_pos = dr > dl;
  assign dh_pos = db > dt;
  assign sw_pos = sr > sl;
  assign sh_pos = sb > st;
  assign scaling   = ((sw_x != dw_x) || (sh_x != dh_x)) && !pad;
  assign bounds_ok = (sr <= s_w) && (sb <= s_h) && (dr <= d_w) && (db <= d_h);

  // walk position against the destination extent
  assign x_end = ({1'b0, column_q} + 1'b1) >= {1'b0, dw_c};
  assign y_end = ({1'b0, row_q} + 1'b1) >= {1'b0, dh_c};
  assign x_in  = column_q < dw_c;
  assign y_in  = row_q < dh_c;

  // one to one source position, clamped or range checked
  assign sx_lin  = {2'b00, sl} + {2'b00, column_q};
  assign sy_lin  = {2'b00, st} + {2'b00, row_q};
  assign sx_pad  = clamp_pad(sx_lin, sl, sr);
  assign sy_pad  = clamp_pad(sy_lin, st, sb);
  assign sx_over = sx_lin >= {2'b00, sr};
  assign sy_over = sy_lin >= {2'b00, sb};

  // scaled source position from the divider
  assign sx_sc = {1'b0, sl} + {1'b0, div_quot};
  assign sy_sc = {1'b0, st} + {1'b0, div_quot};

  // destination position
  assign dy_lin = {1'b0, dt} + {1'b0, y_q};
  assign dx_lin = {1'b0, dl} + {1'b0, x_q};

  // pixel format conversion
  always_comb begin
    if (sfmt == dfmt) begin
      conv_word = sfmt ? s_axis_tdata : {24'd0, s_axis_tdata[7:0]};
    end else if (dfmt) begin
      conv_word = {sba_pkg::ALPHA_OPAQUE, s_axis_tdata[7:0], s_axis_tdata[7:0],
                   s_axis_tdata[7:0]};
    end else begin
      conv_word = {24'd0, s_axis_tdata[7:0]};
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    column_d     = column_q;
    row_d        = row_q;
    running_d    = running_q;
    x_d          = x_q;
    y_d          = y_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    res_d        = res_q;
    out_d        = out_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    mac_en       = 1'b0;
    mac_a        = '0;
    mac_b        = '0;
    mac_c        = '0;
    div_start    = 1'b0;
    div_dividend = mac_res[sba_pkg::DIVD_W-1:0];
    div_divisor  = dw_c;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_d   = '0;
          x_d     = column_q;
          y_d     = row_q;
          state_d = ST_RESP;
          unique case (s_axis_tuser)
            sba_pkg::KIND_START: begin
              res_d.status = !bounds_ok;
              column_d     = '0;
              row_d        = '0;
              running_d    = bounds_ok && dw_pos && dh_pos;
            end
            sba_pkg::KIND_ADVANCE: begin
              if (running_q) begin
                if (!dw_pos || !dh_pos) begin
                  running_d = 1'b0;
                end else begin
                  res_d.last = x_end && y_end;
                  if (x_end) begin
                    column_d = '0;
                    row_d    = row_q + 1'b1;
                    if (y_end) begin
                      running_d = 1'b0;
                    end
                  end else begin
                    column_d = column_q + 1'b1;
                  end
                  if (scaling) begin
                    // beyond the extent the quotient would pass the source edge
                    if (sw_pos && sh_pos && x_in && y_in) begin
                      state_d = ST_MULX;
                    end
                  end else begin
                    sx_d = pad ? sx_pad[CB-1:0] : sx_lin[CB-1:0];
                    sy_d = pad ? sy_pad[CB-1:0] : sy_lin[CB-1:0];
                    if (pad || (!sx_over && !sy_over)) begin
                      state_d = ST_RDOFF;
                    end
                  end
                end
              end
            end
            sba_pkg::KIND_CONVERT: begin
              res_d.word = conv_word;
              res_d.bc   = sba_pkg::pix_bytes(dfmt);
            end
            default: ;
          endcase
        end
      end
      ST_MULX: begin
        mac_en  = 1'b1;
        mac_a   = {1'b0, x_q};
        mac_b   = sba_pkg::MB_W'(sw_c);
        state_d = ST_DIVX;
      end
      ST_DIVX: begin
        div_start = 1'b1;
        state_d   = ST_WAITX;
      end
      ST_WAITX: begin
        if (div_done) begin
          if (sx_sc >= {1'b0, sr}) begin
            state_d = ST_RESP;
          end else begin
            sx_d    = sx_sc[CB-1:0];
            state_d = ST_MULY;
          end
        end
      end
      ST_MULY: begin
        mac_en  = 1'b1;
        mac_a   = {1'b0, y_q};
        mac_b   = sba_pkg::MB_W'(sh_c);
        state_d = ST_DIVY;
      end
      ST_DIVY: begin
        div_start   = 1'b1;
        div_divisor = dh_c;
        state_d     = ST_WAITY;
      end
      ST_WAITY: begin
        if (div_done) begin
          if (sy_sc >= {1'b0, sb}) begin
            state_d = ST_RESP;
          end else begin
            sy_d    = sy_sc[CB-1:0];
            state_d = ST_RDOFF;
          end
        end
      end
      ST_RDOFF: begin
        // source offset: row * pitch + size * column
        mac_en   = 1'b1;
        mac_a    = {1'b0, sy_q};
        mac_b    = sba_pkg::MB_W'(sp);
        mac_c    = sfmt ? sba_pkg::OFF_W'({sx_q, 2'b00}) : sba_pkg::OFF_W'(sx_q);
        res_d.we = 1'b1;
        res_d.bc = sba_pkg::pix_bytes(dfmt);
        state_d  = ST_WROFF;
      end
      ST_WROFF: begin
        // destination offset, source offset taken from the unit
        res_d.rd = mac_res;
        mac_en   = 1'b1;
        mac_a    = dy_lin;
        mac_b    = sba_pkg::MB_W'(dp);
        mac_c    = dfmt ? sba_pkg::OFF_W'({dx_lin, 2'b00}) : sba_pkg::OFF_W'(dx_lin);
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          out_d = res_q;
          if (res_q.we) begin
            out_d.wr = mac_res;
          end
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      column_q  <= '0;
      row_q     <= '0;
      running_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      column_q  <= column_d;
      row_q     <= row_d;
      running_q <= running_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // shared multiply-add
  sba_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .res_o (mac_res)
  );

  // shared divider
  sba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // stream ports
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{sba_pkg::OUT_PAD_W{1'b0}}, out_q.bc, out_q.word, out_q.we,
                          out_q.wr, out_q.rd, out_q.status};

  // after a request the block is busy in the cycle that follows its handshake
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while the previous one was still open");

  // quotients only arrive while the sequencer waits for them
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAITX) || (state_q == ST_WAITY))
    else $error("divider finished outside a wait state");

  // a copying result always carries a pixel size
  a_copy_has_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_q.we |-> (out_q.bc == sba_pkg::PIX_A8) ||
                              (out_q.bc == sba_pkg::PIX_BGRA))
    else $error("copy result without a pixel size");

  // the walk is over once its last pixel is ready to leave
  a_last_stops_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && res_q.last |-> !running_q)
    else $error("walk still running after its last pixel");

endmodule

@@ hdl/sba_mac.sv @@
// shared multiply-add unit with a registered result, a * b + c modulo 2^32
// depends on sba_pkg
module sba_mac (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [sba_pkg::MA_W-1:0]  a_i,
  input  logic [sba_pkg::MB_W-1:0]  b_i,
  input  logic [sba_pkg::OFF_W-1:0] c_i,
  output logic [sba_pkg::OFF_W-1:0] res_o
);

  localparam int PROD_W = sba_pkg::MA_W + sba_pkg::MB_W;

  logic [PROD_W-1:0]         prod;
  logic [sba_pkg::OFF_W-1:0] res_q;

  // product, then wrap to the offset width
  assign prod = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= sba_pkg::OFF_W'(prod) + c_i;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/sba_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// the dividend must be below divisor * 2^CB; depends on sba_pkg
module sba_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sba_pkg::DIVD_W-1:0] dividend_i,
  input  logic [sba_pkg::CB-1:0]     divisor_i,
  output logic                       done_o,
  output logic [sba_pkg::CB-1:0]     quot_o
);

  localparam int CB = sba_pkg::CB;

  logic [CB-1:0]                rem_q, rem_d;
  logic [CB-1:0]                quo_q, quo_d;
  logic [CB-1:0]                dvs_q, dvs_d;
  logic [sba_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CB:0]                  trial;
  logic [CB:0]                  diff;
  logic                         fits;

  // one restoring step
  assign trial = {rem_q, quo_q[CB-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[sba_pkg::DIVD_W-1:CB];
      quo_d  = dividend_i[CB-1:0];
      dvs_d  = divisor_i;
      cnt_d  = sba_pkg::DIV_CNT_W'(CB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[CB-1:0] : trial[CB-1:0];
      quo_d = {quo_q[CB-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sba_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ verif/scaled_blit_address_generator_tb.sv @@
// self-checking testbench of the scaled blit address generator
// depends on sba_pkg and scaled_blit_address_generator, and through it on sba_mac and sba_div
// predicts every result in a scoreboard class and checks it field by field
module scaled_blit_address_generator_tb;
  import sba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXC = (1 << CB) - 1;
  localparam int TOTAL_REQUESTS = 1475;
  localparam int HOLD_OFF_AT = 600;
  localparam int HOLD_OFF_CYCLES = 400;
  // the tuser code that the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // result field positions in tdata
  localparam int RD_LSB = 1;
  localparam int WR_LSB = RD_LSB + OFF_W;
  localparam int WE_LSB = WR_LSB + OFF_W;
  localparam int WD_LSB = WE_LSB + 1;
  localparam int BC_LSB = WD_LSB + WORD_W;

  // expected results of the blit walk, worked out from the block's registers
  class blit_scoreboard;
    logic [RECT_W-1:0]  src_area;
    logic [RECT_W-1:0]  dst_rect;
    logic [SIZE_W-1:0]  src_size;
    logic [SIZE_W-1:0]  dst_size;
    logic [PITCH_W-1:0] pitches;
    logic [MODE_W-1:0]  mode;
    logic [CB-1:0]      col;
    logic [CB-1:0]      row;
    bit                 running;
    res_t               blit_results_q[$];
    int                 failures;

    function new();
      src_area = '0;
      dst_rect = '0;
      src_size = '0;
      dst_size = '0;
      pitches  = '0;
      mode     = '0;
      col      = '0;
      row      = '0;
      running  = 1'b0;
      failures = 0;
    endfunction

    static function longint coord(logic [RECT_W-1:0] bits, int idx);
      return longint'(bits[idx*CB +: CB]);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_SRC_RECT:  src_area = value[RECT_W-1:0];
        REG_DST_RECT:  dst_rect = value[RECT_W-1:0];
        REG_SRC_SIZE:  src_size = value[SIZE_W-1:0];
        REG_DST_SIZE:  dst_size = value[SIZE_W-1:0];
        REG_PITCHES:   pitches  = value[PITCH_W-1:0];
        REG_BLIT_MODE: mode     = value[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // one request of the blitter: updates the walk and returns its result
    function res_t step_blit(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word);
      res_t   r;
      bit     ok, scaling, skip;
      longint s_l, s_t, s_r, s_b, s_w, s_h, d_l, d_t, d_w, d_h;
      longint x, y, sx, sy, src_px, dst_px;
      logic [7:0] b;
      r = '0;
      src_px = mode[MODE_SFMT] ? 4 : 1;
      dst_px = mode[MODE_DFMT] ? 4 : 1;
      case (kind)
        KIND_START: begin
          ok = coord(src_area, 2) <= coord(src_size, 0) && coord(src_area, 3) <= coord(src_size, 1)
            && coord(dst_rect, 2) <= coord(dst_size, 0)
            && coord(dst_rect, 3) <= coord(dst_size, 1);
          r.status = !ok;
          col = '0;
          row = '0;
          running = ok && coord(dst_rect, 2) > coord(dst_rect, 0)
                       && coord(dst_rect, 3) > coord(dst_rect, 1);
        end
        KIND_ADVANCE: begin
          s_l = coord(src_area, 0);
          s_t = coord(src_area, 1);
          s_r = coord(src_area, 2);
          s_b = coord(src_area, 3);
          d_l = coord(dst_rect, 0);
          d_t = coord(dst_rect, 1);
          d_w = coord(dst_rect, 2) - d_l;
          d_h = coord(dst_rect, 3) - d_t;
          s_w = s_r - s_l;
          s_h = s_b - s_t;
          x = longint'(col);
          y = longint'(row);
          if (running) begin
            if (d_w <= 0 || d_h <= 0) begin
              // destination emptied under a running walk
              running = 1'b0;
            end else begin
              scaling = (s_w != d_w || s_h != d_h) && !mode[MODE_PAD];
              skip = 1'b0;
              if (scaling) begin
                if (s_w <= 0 || s_h <= 0) begin
                  skip = 1'b1;
                  sx = s_l;
                  sy = s_t;
                end else begin
                  sx = s_l + (x * s_w) / d_w;
                  sy = s_t + (y * s_h) / d_h;
                end
              end else begin
                sx = s_l + x;
                sy = s_t + y;
              end
              // repeat padding clamps to the source edges
              if (mode[MODE_PAD]) begin
                if (sx > s_r - 1) sx = s_r - 1;
                if (sx < s_l) sx = s_l;
                if (sy > s_b - 1) sy = s_b - 1;
                if (sy < s_t) sy = s_t;
              end else if (sx >= s_r || sy >= s_b) begin
                skip = 1'b1;
              end
              if (!skip) begin
                r.rd = OFF_W'(sy * longint'(pitches[PB-1:0]) + src_px * sx);
                r.wr = OFF_W'((d_t + y) * longint'(pitches[PITCH_W-1:PB]) + dst_px * (d_l + x));
                r.we = 1'b1;
                r.bc = mode[MODE_DFMT] ? PIX_BGRA : PIX_A8;
              end
              r.last = (x + 1 >= d_w) && (y + 1 >= d_h);
              if (x + 1 >= d_w) begin
                col = '0;
                row = CB'(y + 1);
                if (y + 1 >= d_h) running = 1'b0;
              end else begin
                col = CB'(x + 1);
              end
            end
          end
        end
        KIND_CONVERT: begin
          b = word[7:0];
          if (mode[MODE_SFMT] == mode[MODE_DFMT]) begin
            r.word = mode[MODE_SFMT] ? word : {24'd0, b};
          end else if (mode[MODE_DFMT]) begin
            r.word = {ALPHA_OPAQUE, b, b, b};
          end else begin
            r.word = {24'd0, b};
          end
          r.bc = mode[MODE_DFMT] ? PIX_BGRA : PIX_A8;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word);
      blit_results_q.push_back(step_blit(kind, word));
    endfunction

    function int pending();
      return blit_results_q.size();
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
      res_t want;
      if (blit_results_q.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = blit_results_q.pop_front();
        cmp_field("status", 64'(want.status), 64'(data[0]));
        cmp_field("read_offset", 64'(want.rd), 64'(data[RD_LSB +: OFF_W]));
        cmp_field("write_offset", 64'(want.wr), 64'(data[WR_LSB +: OFF_W]));
        cmp_field("write_enable", 64'(want.we), 64'(data[WE_LSB]));
        cmp_field("out_word", 64'(want.word), 64'(data[WD_LSB +: WORD_W]));
        cmp_field("byte_count", 64'(want.bc), 64'(data[BC_LSB +: BC_W]));
        cmp_field("last_pixel", 64'(want.last), 64'(last));
        cmp_field("padding", 64'd0, 64'(data >> RES_W));
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // src_word
  logic [KIND_W-1:0]      s_axis_tuser = '0;  // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // status, read_offset, write_offset, write_enable, out_word, byte_count, zeros
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;       // last_pixel

  blit_scoreboard sb = new();
  int requests_taken = 0;
  int burst_left = 0;

  scaled_blit_address_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [RECT_W-1:0] pack_rect(int l, int t, int r, int b);
    return {CB'(b), CB'(r), CB'(t), CB'(l)};
  endfunction

  // left or top edge for a span, inverted spans kept inside the coordinate range
  function automatic int place(int span);
    int lo, hi;
    lo = (span < 0) ? -span : 0;
    hi = MAXC - ((span > 0) ? span : 0);
    case ($urandom_range(0, 5))
      0: return hi;
      1: return int'($urandom_range(hi, lo));
      default: return int'($urandom_range((hi < lo + 40) ? hi : lo + 40, lo));
    endcase
  endfunction

  // bitmap dimension for a rectangle edge, now and then too small
  function automatic logic [CB-1:0] bitmap_dim(int far_side);
    int tmp;
    case ($urandom_range(0, 19))
      0: return CB'((far_side > 0) ? far_side - 1 : 0);
      1: return CB'($urandom);
      default: begin
        tmp = far_side + int'($urandom_range(0, 3));
        return CB'((tmp > MAXC) ? MAXC : tmp);
      end
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_register(idx, value);
  endtask

  // one request, in bursts with random gaps
  task automatic send_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, word);
    requests_taken++;
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result receiver with its own stall pattern and one long hold-off
  initial begin
    int style, len, k;
    bit held_off;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && requests_taken >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      style = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      for (k = 0; k < len; k++) begin
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= (k % 4 == 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // stimulus
  initial begin
    int dw, dh, dl, dt, sw, sh, sl, st, wl, hl, walk, n_adv, pick, phase_no;
    bit all_regs;
    logic [RECT_W-1:0]  src_r, dst_r;
    logic [SIZE_W-1:0]  src_s, dst_s;
    logic [PITCH_W-1:0] pit;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: empty walk, idle advance, A8 to A8 convert, ignored kind
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_CONVERT, 32'hA5A5_A5C3);
    send_request(KIND_UNUSED, 32'hFFFF_FFFF);
    drain();

    // one-to-one copy, A8 to BGRA8, all-ones pitches and bitmap sizes
    write_reg(REG_SRC_RECT, CFG_W'(pack_rect(1, 1, 3, 2)));
    write_reg(REG_DST_RECT, CFG_W'(pack_rect(0, 0, 2, 1)));
    write_reg(REG_SRC_SIZE, CFG_W'({CB'(MAXC), CB'(MAXC)}));
    write_reg(REG_DST_SIZE, CFG_W'({CB'(MAXC), CB'(MAXC)}));
    write_reg(REG_PITCHES, CFG_W'({PITCH_W{1'b1}}));
    write_reg(REG_BLIT_MODE, CFG_W'(3'b010));
    cfg_we_i <= 1'b0;
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_CONVERT, 32'h0000_00FF);
    drain();

    // padding from an inverted source into the far corner, BGRA8 to A8
    write_reg(REG_SRC_RECT, CFG_W'(pack_rect(5, 5, 3, 3)));
    write_reg(REG_DST_RECT, CFG_W'(pack_rect(MAXC - 2, MAXC - 1, MAXC, MAXC)));
    write_reg(REG_BLIT_MODE, CFG_W'(3'b101));
    cfg_we_i <= 1'b0;
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_CONVERT, 32'hDEAD_BEEF);
    drain();

    // scaling from an empty source skips every pixel
    write_reg(REG_SRC_RECT, CFG_W'(pack_rect(4, 4, 4, 4)));
    write_reg(REG_DST_RECT, CFG_W'(pack_rect(0, 0, 3, 1)));
    write_reg(REG_BLIT_MODE, CFG_W'(3'b000));
    cfg_we_i <= 1'b0;
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    drain();

    // destination out of bounds: rejected start, walk stays idle
    write_reg(REG_DST_SIZE, CFG_W'({CB'(1), CB'(2)}));
    cfg_we_i <= 1'b0;
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    drain();

    // restart while running, then the destination emptied mid-walk
    write_reg(REG_DST_SIZE, CFG_W'({CB'(MAXC), CB'(MAXC)}));
    write_reg(REG_SRC_RECT, CFG_W'(pack_rect(0, 0, 7, 5)));
    write_reg(REG_DST_RECT, CFG_W'(pack_rect(0, 0, 2, 2)));
    write_reg(REG_BLIT_MODE, CFG_W'(3'b011));
    cfg_we_i <= 1'b0;
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_START, 32'h0);
    send_request(KIND_ADVANCE, 32'h0);
    send_request(KIND_CONVERT, 32'h1234_5678);
    drain();
    write_reg(REG_DST_RECT, CFG_W'(pack_rect(2, 2, 2, 2)));
    cfg_we_i <= 1'b0;
    send_request(KIND_ADVANCE, 32'h0);
    drain();

    // random blits, each with fresh registers in part or in full
    phase_no = 0;
    while (requests_taken < TOTAL_REQUESTS) begin
      all_regs = (phase_no == 0) || ($urandom_range(0, 2) == 0);

      // destination rectangle: mostly small, sometimes empty or inverted
      dw = $urandom_range(1, 5);
      dh = $urandom_range(1, 4);
      case ($urandom_range(0, 11))
        0: dw = -int'($urandom_range(0, 2));
        1: dh = -int'($urandom_range(0, 2));
        2: begin
          dw = $urandom_range(6, 16);
          dh = $urandom_range(1, 3);
        end
        default: ;
      endcase
      dl = place(dw);
      dt = place(dh);
      dst_r = pack_rect(dl, dt, dl + dw, dt + dh);
      if ($urandom_range(0, 24) == 0) dst_r = RECT_W'({$urandom, $urandom});

      // source rectangle: same size, scaled, huge, or empty
      case ($urandom_range(0, 5))
        0, 1: begin
          sw = dw;
          sh = dh;
        end
        2, 3: begin
          sw = $urandom_range(1, 12);
          sh = $urandom_range(1, 8);
        end
        4: begin
          sw = $urandom_range(1, MAXC);
          sh = $urandom_range(1, MAXC);
        end
        default: begin
          sw = 2 - int'($urandom_range(0, 5));
          sh = 2 - int'($urandom_range(0, 5));
          if (sw > 0 && sh > 0) sh = 0;
        end
      endcase
      sl = place(sw);
      st = place(sh);
      src_r = pack_rect(sl, st, sl + sw, st + sh);
      if ($urandom_range(0, 24) == 0) src_r = RECT_W'({$urandom, $urandom});

      src_s = {bitmap_dim(int'(src_r[3*CB +: CB])), bitmap_dim(int'(src_r[2*CB +: CB]))};
      dst_s = {bitmap_dim(int'(dst_r[3*CB +: CB])), bitmap_dim(int'(dst_r[2*CB +: CB]))};
      case ($urandom_range(0, 7))
        0: pit = '0;
        1: pit = '1;
        default: pit = PITCH_W'($urandom);
      endcase

      if (all_regs || $urandom_range(0, 1) == 0) write_reg(REG_SRC_RECT, CFG_W'(src_r));
      if (all_regs || $urandom_range(0, 1) == 0) write_reg(REG_DST_RECT, CFG_W'(dst_r));
      if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_SRC_SIZE, CFG_W'(src_s));
      if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_DST_SIZE, CFG_W'(dst_s));
      if (all_regs || $urandom_range(0, 2) == 0) write_reg(REG_PITCHES, CFG_W'(pit));
      if (all_regs || $urandom_range(0, 1) == 0) begin
        write_reg(REG_BLIT_MODE, CFG_W'($urandom_range(0, 7)));
      end
      cfg_we_i <= 1'b0;

      // mostly a full walk; sometimes the old walk goes on under new registers
      if ($urandom_range(0, 7) != 0) send_request(KIND_START, $urandom);
      wl = int'(sb.coord(sb.dst_rect, 2) - sb.coord(sb.dst_rect, 0));
      hl = int'(sb.coord(sb.dst_rect, 3) - sb.coord(sb.dst_rect, 1));
      walk = (wl > 0 && hl > 0) ? wl * hl : 0;
      n_adv = ((walk > 40) ? 40 : walk) + int'($urandom_range(0, 2));
      repeat (n_adv) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) send_request(KIND_CONVERT, $urandom);
        else if (pick < 14) send_request(KIND_UNUSED, $urandom);
        else if (pick < 15) send_request(KIND_START, $urandom);
        send_request(KIND_ADVANCE, $urandom);
      end
      drain();
      phase_no++;
    end

    repeat (40) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sba_pkg.sv
hdl/sba_mac.sv
hdl/sba_div.sv
hdl/scaled_blit_address_generator.sv
verif/scaled_blit_address_generator_tb.sv
